// ===== hw/rtl/integer_ascii_formatter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Integer ASCII formatter assertion macros
// Shared assertions on clk; IAF_ASSERT is off during active-low reset rst_n.
// ----------------------------------------------------------------------------
`ifndef INTEGER_ASCII_FORMATTER_UNIT_ASSERT_SVH
`define INTEGER_ASCII_FORMATTER_UNIT_ASSERT_SVH

// check outside of reset
`define IAF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge, reset included
`define IAF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/iaf_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer ASCII formatter package
// Command codes, character constants, control and status types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iaf_pkg;

  localparam logic [2:0] CMD_SDEC  = 3'd0;
  localparam logic [2:0] CMD_UDEC  = 3'd1;
  localparam logic [2:0] CMD_HEXL  = 3'd2;
  localparam logic [2:0] CMD_HEXU  = 3'd3;
  localparam logic [2:0] CMD_PTR   = 3'd4;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_X      = 8'h78;

  localparam logic [63:0] RECIP_TEN = 64'h0000_0000_CCCC_CCCD;

  typedef struct packed {
    logic load;
    logic div_step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cmd_ok;
    logic in_dec;
    logic q_zero;
    logic pre_left;
    logic ptr_zero;
    logic out_free;
  } dp_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'd0, d};
    end else begin
      digit_char = base + {4'd0, d} - 8'd10;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/iaf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Integer ASCII formatter controller
// Sequences load, decimal digit extraction and character emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iaf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire iaf_pkg::dp_stat_t st,
  output iaf_pkg::ctrl_cmd_t     ctl
);
  import iaf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    ctl.load     = 1'b0;
    ctl.div_step = 1'b0;
    ctl.emit     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && st.cmd_ok) begin
          ctl.load  = 1'b1;
          state_nxt = st.in_dec ? ST_CONV : ST_EMIT;
        end
      end
      ST_CONV: begin
        ctl.div_step = 1'b1;
        if (st.q_zero) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (st.out_free) begin
          ctl.emit = 1'b1;
          if (!st.pre_left && st.ptr_zero) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/iaf_datapath.sv =====
// ----------------------------------------------------------------------------
// Integer ASCII formatter datapath
// Digit store, divide-by-ten step, prefix logic and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iaf_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire iaf_pkg::ctrl_cmd_t ctl,
  output iaf_pkg::dp_stat_t       st,
  input  wire logic [2:0]         in_cmd,
  input  wire logic [63:0]        in_value,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [7:0]              out_char_code,
  output logic                    out_last
);
  import iaf_pkg::*;

  logic [2:0]  mode_r;
  logic [31:0] val_r;
  logic [3:0]  dig_r [16];
  logic [3:0]  ptr_r;
  logic [1:0]  pre_cnt_r;
  logic [1:0]  pre_idx_r;
  logic        out_valid_r;
  logic [7:0]  out_char_r;
  logic        out_last_r;

  logic [31:0] low;
  logic        is_dec;
  logic        neg;
  logic [31:0] mag;
  logic [63:0] hex_src;
  logic [3:0]  top_idx;
  logic [63:0] prod;
  logic [31:0] quo;
  logic [31:0] quo_x10;
  logic [31:0] rem_full;
  logic        pre_left;
  logic [7:0]  pre_char;

  assign low     = in_value[31:0];
  assign is_dec  = in_cmd inside {CMD_SDEC, CMD_UDEC};
  assign neg     = (in_cmd == CMD_SDEC) && low[31];
  assign mag     = neg ? (32'd0 - low) : low;
  assign hex_src = (in_cmd == CMD_PTR) ? in_value : {32'd0, low};

  always_comb begin
    top_idx = 4'd0;
    for (int i = 1; i < 16; i++) begin
      if (hex_src[i*4 +: 4] != 4'd0) begin
        top_idx = 4'(i);
      end
    end
  end

  assign prod     = {32'd0, val_r} * RECIP_TEN;
  assign quo      = {3'd0, prod[63:35]};
  assign quo_x10  = {quo[28:0], 3'd0} + {quo[30:0], 1'b0};
  assign rem_full = val_r - quo_x10;

  assign pre_left = (pre_idx_r != pre_cnt_r);

  always_comb begin
    if (mode_r == CMD_PTR) begin
      pre_char = (pre_idx_r == 2'd0) ? CH_ZERO : CH_X;
    end else begin
      pre_char = CH_MINUS;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mode_r    <= in_cmd;
      val_r     <= mag;
      ptr_r     <= is_dec ? 4'd0 : top_idx;
      pre_cnt_r <= neg ? 2'd1 : ((in_cmd == CMD_PTR) ? 2'd2 : 2'd0);
      pre_idx_r <= 2'd0;
      if (!is_dec) begin
        for (int i = 0; i < 16; i++) begin
          dig_r[i] <= hex_src[i*4 +: 4];
        end
      end
    end
    if (ctl.div_step) begin
      dig_r[ptr_r] <= rem_full[3:0];
      val_r        <= quo;
      if (quo != 32'd0) begin
        ptr_r <= ptr_r + 4'd1;
      end
    end
    if (ctl.emit) begin
      if (pre_left) begin
        out_char_r <= pre_char;
        out_last_r <= 1'b0;
        pre_idx_r  <= pre_idx_r + 2'd1;
      end else begin
        out_char_r <= digit_char(dig_r[ptr_r], mode_r == CMD_HEXU);
        out_last_r <= (ptr_r == 4'd0);
        ptr_r      <= ptr_r - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign st.cmd_ok   = (in_cmd <= CMD_PTR);
  assign st.in_dec   = is_dec;
  assign st.q_zero   = (quo == 32'd0);
  assign st.pre_left = pre_left;
  assign st.ptr_zero = (ptr_r == 4'd0);
  assign st.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

// ===== hw/rtl/integer_ascii_formatter_unit.sv =====
// Hex and pointer text: load, then the emit state fills the output register.
// Decimal text: one divide-by-ten step per digit (1 to 10) comes first. One
// character per cycle leaves the output register while out_ready is high.
// A new item is accepted only after the last character of the current one.
// Reset: synchronous active-low rst_n clears the controller and output valid.
// ----------------------------------------------------------------------------
// Integer ASCII formatter unit
// Formats a number as signed/unsigned decimal, hex or pointer text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "integer_ascii_formatter_unit_assert.svh"

module integer_ascii_formatter_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [63:0] in_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_char_code,
  output logic             out_last
);
  import iaf_pkg::*;

  ctrl_cmd_t ctl;
  dp_stat_t  st;

  iaf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .ctl      (ctl)
  );

  iaf_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .st            (st),
    .in_cmd        (in_cmd),
    .in_value      (in_value),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

  `IAF_ASSERT_ALWAYS(a_rst_clears_out, !rst_n |=> !out_valid, "output valid after reset")
  `IAF_ASSERT(a_busy_after_accept, in_valid && in_ready && (in_cmd <= CMD_PTR) |=> !in_ready,
    "input ready right after a formatted transaction")
  `IAF_ASSERT(a_emit_needs_slot, ctl.emit |-> (!out_valid || out_ready),
    "character emitted over a held output")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Integer ASCII formatter testbench
// Drives numbers in every format command through the valid/ready input and
// checks each emitted character and its last flag against a predicted text.
// The traffic covers directed corner values, then random values under phases
// of sender idling, receiver stalls and a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import iaf_pkg::*;

  localparam int          RESET_CYCLES = 8;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          RANDOM_ITEMS = 385;
  localparam logic [2:0]  CMD_RSVD_LO  = 3'd5;
  localparam logic [2:0]  CMD_RSVD_HI  = 3'd7;

  class text_scoreboard;
    typedef struct {
      logic [7:0] code;
      logic       last;
    } text_char_t;

    text_char_t pending_chars[$];
    int         errors = 0;

    function void add_number(logic [2:0] cmd, logic [63:0] value);
      logic [7:0]  text[$];
      logic [7:0]  digits[$];
      logic [63:0] mag;
      logic [63:0] base;
      logic [31:0] low;
      logic [3:0]  d;
      logic        upper;
      text_char_t  c;
      low   = value[31:0];
      upper = 1'b0;
      base  = 64'd16;
      case (cmd)
        CMD_SDEC: begin
          base = 64'd10;
          mag  = {32'd0, low};
          if (low[31]) begin
            text.push_back(CH_MINUS);
            mag = {32'd0, 32'd0 - low};
          end
        end
        CMD_UDEC: begin
          base = 64'd10;
          mag  = {32'd0, low};
        end
        CMD_HEXL: mag = {32'd0, low};
        CMD_HEXU: begin
          mag   = {32'd0, low};
          upper = 1'b1;
        end
        CMD_PTR: begin
          mag = value;
          text.push_back(CH_ZERO);
          text.push_back(CH_X);
        end
        default: return;
      endcase
      do begin
        d = 4'(mag % base);
        if (d < 4'd10) begin
          digits.push_front(CH_ZERO + {4'd0, d});
        end else begin
          digits.push_front((upper ? CH_UPPER_A : CH_LOWER_A) + {4'd0, d} - 8'd10);
        end
        mag = mag / base;
      end while (mag != 64'd0);
      foreach (digits[i]) text.push_back(digits[i]);
      foreach (text[i]) begin
        c.code = text[i];
        c.last = (i == text.size() - 1);
        pending_chars.push_back(c);
      end
    endfunction

    function void check_char(logic [7:0] code, logic last);
      text_char_t exp_c;
      if (pending_chars.size() == 0) begin
        $error("unexpected character: char_code %h last %b", code, last);
        errors++;
        return;
      end
      exp_c = pending_chars.pop_front();
      if (code !== exp_c.code) begin
        $error("char_code mismatch: expected %h, actual %h", exp_c.code, code);
        errors++;
      end
      if (last !== exp_c.last) begin
        $error("last mismatch: expected %b, actual %b", exp_c.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_cmd = '0;
  logic [63:0] in_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_char_code;
  logic        out_last;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_seq = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          cycle_count = 0;

  text_scoreboard sb = new();

  integer_ascii_formatter_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_char(out_char_code, out_last);
    end
  end

  task automatic send_number(logic [2:0] cmd, logic [63:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    sb.add_number(cmd, value);
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    logic [63:0] p;
    int          k;
    case ($urandom_range(5))
      0: v = {$urandom, $urandom};
      1: v = 64'($urandom_range(20));
      2: v = {$urandom, $urandom} >> $urandom_range(63);
      3: begin
        v = {$urandom, 32'h8000_0000};
        if ($urandom_range(1)) v[31:0] = 32'hFFFF_FFFF;
        v[31:0] = v[31:0] + 32'($urandom_range(4)) - 32'd2;
      end
      4: begin
        p = 64'd1;
        k = $urandom_range(19);
        repeat (k) p = p * (($urandom_range(1) != 0) ? 64'd10 : 64'd16);
        v = p + 64'($urandom_range(2)) - 64'd1;
      end
      default: v = {64{1'b1}} >> $urandom_range(63);
    endcase
    return v;
  endfunction

  task automatic run_random(int count);
    logic [2:0] cmd;
    int         sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        cmd = 3'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
      end else begin
        cmd = 3'($urandom_range(CMD_PTR, CMD_SDEC));
      end
      sent++;
      send_number(cmd, pick_value());
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_number(CMD_SDEC, 64'd0);
    send_number(CMD_SDEC, 64'h0000_0000_7FFF_FFFF);
    send_number(CMD_SDEC, 64'h0000_0000_8000_0000);
    send_number(CMD_SDEC, 64'h0000_0000_FFFF_FFFF);
    send_number(CMD_SDEC, 64'hFFFF_FFFF_0000_0000);
    send_number(CMD_SDEC, 64'h1234_5678_FFFF_FFF6);
    send_number(CMD_UDEC, 64'd0);
    send_number(CMD_UDEC, 64'h0000_0000_FFFF_FFFF);
    send_number(CMD_UDEC, 64'hFFFF_FFFF_3B9A_CA00);
    send_number(CMD_UDEC, 64'd9);
    send_number(CMD_HEXL, 64'd0);
    send_number(CMD_HEXL, 64'hFFFF_FFFF_DEAD_BEEF);
    send_number(CMD_HEXL, 64'h0000_0000_0000_000F);
    send_number(CMD_HEXU, 64'd0);
    send_number(CMD_HEXU, 64'h0000_0000_ABCD_EF01);
    send_number(CMD_HEXU, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(CMD_PTR, 64'd0);
    send_number(CMD_PTR, 64'd1);
    send_number(CMD_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(CMD_PTR, 64'hFFFF_FFFF_0000_0000);
    send_number(CMD_PTR, 64'h0000_0000_FFFF_FFFF);
    for (int c = CMD_RSVD_LO; c <= CMD_RSVD_HI; c++) begin
      send_number(3'(c), {$urandom, $urandom});
    end
    send_number(CMD_PTR, 64'h8000_0000_0000_0000);

    run_random(RANDOM_ITEMS / 5);

    send_idle_pct  = 51;
    recv_stall_pct = 0;
    run_random(RANDOM_ITEMS / 5);

    send_idle_pct  = 0;
    recv_stall_pct = 51;
    run_random(RANDOM_ITEMS / 5);

    send_idle_pct  = 11;
    recv_stall_pct = 11;
    run_random(RANDOM_ITEMS / 5);

    // hold the receiver off while the sender keeps offering
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_seq <= hold_seq + 1;
    run_random(RANDOM_ITEMS - 4 * (RANDOM_ITEMS / 5));

    in_valid <= 1'b0;
    while (sb.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending_chars.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/iaf_pkg.sv
hw/rtl/iaf_ctrl.sv
hw/rtl/iaf_datapath.sv
hw/rtl/integer_ascii_formatter_unit.sv
verif/tb_top.sv
